>>> rtl/inpc_pkg.sv
// ----------------------------------------------------------------------------
// inpc_pkg - shared types and constants of the indexed NVRAM port controller
// Holds the access codes, register indexes, status bytes and the structs
// passed between the control and memory parts.
// ----------------------------------------------------------------------------
package inpc_pkg;

    localparam int DATA_W  = 8;
    localparam int DELAY_W = 24;

    // Access mode of one beat
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2
    } mode_t;

    // Port selected by one beat
    typedef enum logic [1:0] {
        PORT_STATE = 2'd0,
        PORT_ADDR  = 2'd1,
        PORT_DATA  = 2'd2
    } port_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_READ_DELAY  = 1'b0,
        CFG_WRITE_DELAY = 1'b1
    } cfg_idx_t;

    localparam logic [DATA_W-1:0]  STATUS_BASE        = 8'h01;
    localparam logic [DATA_W-1:0]  STATUS_READY_BITS  = 8'h06;
    localparam logic [DELAY_W-1:0] READ_DELAY_RESET   = 24'd1;
    localparam logic [DELAY_W-1:0] WRITE_DELAY_RESET  = 24'd10000;
    localparam logic [DELAY_W-1:0] ADDR_BUSY_TICKS    = 24'd1;

    // Memory access request from control to memory
    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [DATA_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } mem_req_t;

    // Registered result of one beat
    typedef struct packed {
        logic              valid;
        logic              from_mem;
        logic [DATA_W-1:0] data;
        logic              ready;
    } res_t;

endpackage

>>> rtl/inpc_mem.sv
// ----------------------------------------------------------------------------
// inpc_mem - byte memory of the NVRAM controller
// Synchronous single-port memory with a registered read. Per-entry
// valid bits make entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module inpc_mem
    import inpc_pkg::*;
#(
    parameter int MEM_DEPTH = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  mem_req_t          req,
    output logic [DATA_W-1:0] rdata
);

    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic [DATA_W-1:0] mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] valid_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic              hit_reg;
    logic              in_range;
    logic [AW-1:0]     addr;

    // Guard addresses beyond the memory
    assign in_range = ({1'b0, req.addr} < (DATA_W+1)'(MEM_DEPTH));
    assign addr     = AW'(req.addr);

    // Store write data and read the addressed byte
    always_ff @(posedge clk)
    begin
        if (req.wr && in_range)
        begin
            mem[addr] <= req.wdata;
        end
        if (req.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    // Track written entries and the hit of the last read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (req.wr && in_range)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (req.rd)
            begin
                hit_reg <= in_range && valid_reg[addr];
            end
        end
    end

    // Drop data of unwritten or out-of-range entries
    assign rdata = hit_reg ? rdata_reg : '0;

endmodule

>>> rtl/inpc_ctrl.sv
// ----------------------------------------------------------------------------
// inpc_ctrl - access decoder of the NVRAM controller
// Decodes each beat, keeps the index register and the busy count, issues
// memory requests and registers the result of the beat.
// ----------------------------------------------------------------------------
module inpc_ctrl
    import inpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [1:0]         mode,
    input  logic [1:0]         port,
    input  logic [DATA_W-1:0]  write_data,
    input  logic [DELAY_W-1:0] read_delay,
    input  logic [DELAY_W-1:0] write_delay,
    output mem_req_t           mem_req,
    output res_t               res
);

    logic [DATA_W-1:0]  index_reg;
    logic [DATA_W-1:0]  index_next;
    logic [DELAY_W-1:0] busy_cnt_reg;
    logic [DELAY_W-1:0] busy_cnt_next;
    res_t               res_reg;
    res_t               res_next;
    logic               ready_now;

    assign ready_now = (busy_cnt_reg == '0);

    // Decode the beat
    always_comb
    begin
        index_next       = index_reg;
        busy_cnt_next    = busy_cnt_reg;
        mem_req.rd       = 1'b0;
        mem_req.wr       = 1'b0;
        mem_req.addr     = index_reg;
        mem_req.wdata    = write_data;
        res_next.valid   = accept;
        res_next.from_mem = 1'b0;
        res_next.data    = '0;
        if (accept)
        begin
            unique case (mode_t'(mode))
                MODE_TICK:
                begin
                    if (!ready_now)
                    begin
                        busy_cnt_next = busy_cnt_reg - DELAY_W'(1);
                    end
                end
                MODE_READ:
                begin
                    unique case (port_t'(port))
                        PORT_STATE:
                        begin
                            res_next.data = STATUS_BASE
                                | (ready_now ? STATUS_READY_BITS : '0);
                        end
                        PORT_ADDR:
                        begin
                            if (ready_now)
                            begin
                                res_next.data = index_reg;
                                busy_cnt_next = ADDR_BUSY_TICKS;
                            end
                        end
                        PORT_DATA:
                        begin
                            if (ready_now)
                            begin
                                mem_req.rd        = 1'b1;
                                res_next.from_mem = 1'b1;
                                busy_cnt_next     = read_delay;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                MODE_WRITE:
                begin
                    unique case (port_t'(port))
                        PORT_ADDR:
                        begin
                            if (ready_now)
                            begin
                                index_next    = write_data;
                                busy_cnt_next = ADDR_BUSY_TICKS;
                            end
                        end
                        PORT_DATA:
                        begin
                            if (ready_now)
                            begin
                                mem_req.wr    = 1'b1;
                                busy_cnt_next = write_delay;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
        res_next.ready = (busy_cnt_next == '0);
    end

    // Advance state and register the result of the beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg    <= '0;
            busy_cnt_reg <= '0;
            res_reg      <= '0;
        end
        else
        begin
            index_reg    <= index_next;
            busy_cnt_reg <= busy_cnt_next;
            res_reg      <= res_next;
        end
    end

    assign res = res_reg;

endmodule

>>> rtl/indexed_nvram_port_controller_core.sv
// ----------------------------------------------------------------------------
// indexed_nvram_port_controller_core - byte-wide NVRAM port controller
// Three ports (state, address, data) over a byte memory, with configurable
// busy delays after data accesses.
//
//   channel  | signals                             | handshake
//   ---------+-------------------------------------+---------------------------
//   request  | mode, port, write_data              | start & !busy
//   result   | read_data, ready_res                | done, one cycle
//   config   | cfg_index, cfg_data                 | cfg_write
//
// Each beat is taken at the accepting edge: state updates and the memory
// access happen there, and the result shows with done in the next cycle. A
// new beat can be taken every cycle, so busy stays low. Reset clears the
// index register, the busy count and the memory valid bits, and loads the
// default delays; the memory then reads as zero. The receiver cannot stall
// the result.
// ----------------------------------------------------------------------------
module indexed_nvram_port_controller_core
    import inpc_pkg::*;
#(
    parameter int MEM_DEPTH = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic [1:0]         port,
    input  logic [DATA_W-1:0]  write_data,
    output logic               done,
    output logic [DATA_W-1:0]  read_data,
    output logic               ready_res,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [DELAY_W-1:0] cfg_data
);

    logic [DELAY_W-1:0] read_delay_reg;
    logic [DELAY_W-1:0] write_delay_reg;
    logic               accept;
    mem_req_t           mem_req;
    res_t               res;
    logic [DATA_W-1:0]  mem_rdata;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Write the delay registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_delay_reg  <= READ_DELAY_RESET;
            write_delay_reg <= WRITE_DELAY_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_READ_DELAY:  read_delay_reg  <= cfg_data;
                CFG_WRITE_DELAY: write_delay_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    inpc_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (mode),
        .port        (port),
        .write_data  (write_data),
        .read_delay  (read_delay_reg),
        .write_delay (write_delay_reg),
        .mem_req     (mem_req),
        .res         (res)
    );

    inpc_mem #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_mem
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // Select the result byte
    assign done      = res.valid;
    assign read_data = res.from_mem ? mem_rdata : res.data;
    assign ready_res = res.ready;

endmodule
